### rtl/bounded_deque_with_delete_core_defines.svh
// assertion macros for the bounded deque core checker
// no dependencies; included by the checker file only
`ifndef BOUNDED_DEQUE_WITH_DELETE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_DELETE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, sampled on clk, off during reset
`define BDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

### rtl/bdd_pkg.sv
// shared types and codes for the bounded deque core
// no dependencies; used by the core and the checker
package bdd_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DELETE     = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]                opcode;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        status_t                   status;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

endpackage

### rtl/bdd_ram.sv
// entry ram: one write port, one read port with registered read data
// no dependencies; instantiated by bounded_deque_with_delete_core
module bdd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data registered in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bounded_deque_with_delete_core.sv
// bounded deque core: ring of entries in a one-read one-write ram, front index and count
// push, clear and unused codes answer from idle; a pop reads the ram in idle and answers from
// S_POP_RD; delete: scan of 1 ram read per cycle from the front, then a shift of 1 entry per cycle
// requests are taken only in idle; a stalled response parks in S_RESP and holds req_ready low
// reset: asynchronous, clears front index, count, sequencer and handshake; ram not cleared
// depends on bdd_pkg and bdd_ram
module bounded_deque_with_delete_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bdd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bdd_pkg::rsp_t rsp
);

    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int SW    = CW + 1;
    localparam int EXT_W = (DATA_WIDTH > bdd_pkg::VALUE_W) ? DATA_WIDTH : bdd_pkg::VALUE_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // ring position of an offset from the front
    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    bdd_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   iss_reg, iss_next;
    logic [CW-1:0]   ridx_reg, ridx_next;
    logic            rv_reg, rv_next;
    logic            out_valid_reg, out_valid_next;
    bdd_pkg::rsp_t   out_reg, out_next;
    bdd_pkg::rsp_t   res_reg, res_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  emit;
    bdd_pkg::status_t      emit_status;
    logic [bdd_pkg::VALUE_W-1:0] emit_popped;
    bdd_pkg::rsp_t         emit_rsp;
    logic [EXT_W-1:0]      rd_ext;
    logic [DATA_WIDTH-1:0] req_word;
    logic [IW-1:0]         front_dec;
    logic [IW-1:0]         front_inc;

    bdd_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // word views and front neighbors
    assign req_word  = DATA_WIDTH'(req.value);
    assign rd_ext    = EXT_W'(signed'(rd_data));
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IW'(1);

    assign req_ready = (state_reg == bdd_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // sequencer: next state, ram access and response
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        ridx_next      = ridx_reg;
        rv_next        = 1'b0;
        word_next      = word_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = '0;
        emit           = 1'b0;
        emit_status    = bdd_pkg::STATUS_OK;
        emit_popped    = '0;

        case (state_reg)
            bdd_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (bdd_pkg::op_t'(req.opcode))
                        bdd_pkg::OP_PUSH_BACK:
                        begin
                            emit = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                emit_status = bdd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ring_pos(front_reg, count_reg);
                                wr_data    = req_word;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdd_pkg::OP_PUSH_FRONT:
                        begin
                            emit = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                emit_status = bdd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                wr_data    = req_word;
                                front_next = front_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdd_pkg::OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = bdd_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = ring_pos(front_reg, count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = bdd_pkg::S_POP_RD;
                            end
                        end
                        bdd_pkg::OP_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = bdd_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                front_next = front_inc;
                                count_next = count_reg - CW'(1);
                                state_next = bdd_pkg::S_POP_RD;
                            end
                        end
                        bdd_pkg::OP_DELETE:
                        begin
                            word_next = req_word;
                            if (count_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = bdd_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                iss_next   = '0;
                                state_next = bdd_pkg::S_SCAN;
                            end
                        end
                        bdd_pkg::OP_CLEAR:
                        begin
                            emit       = 1'b1;
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            // pop data back from the ram
            bdd_pkg::S_POP_RD:
            begin
                emit        = 1'b1;
                emit_popped = rd_ext[bdd_pkg::VALUE_W-1:0];
            end

            // walk from the front, compare the registered read data with the search word
            bdd_pkg::S_SCAN:
            begin
                if (rv_reg && (rd_data == word_reg))
                begin
                    iss_next   = ridx_reg + CW'(1);
                    state_next = bdd_pkg::S_SHIFT;
                end
                else if (rv_reg && (ridx_reg == count_reg - CW'(1)))
                begin
                    emit        = 1'b1;
                    emit_status = bdd_pkg::STATUS_NOT_FOUND;
                end
                else if (iss_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ring_pos(front_reg, iss_reg);
                    iss_next  = iss_reg + CW'(1);
                    ridx_next = iss_reg;
                    rv_next   = 1'b1;
                end
            end

            // move each later entry one place toward the front
            bdd_pkg::S_SHIFT:
            begin
                if (rv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ring_pos(front_reg, ridx_reg - CW'(1));
                    wr_data = rd_data;
                end
                if (iss_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ring_pos(front_reg, iss_reg);
                    iss_next  = iss_reg + CW'(1);
                    ridx_next = iss_reg;
                    rv_next   = 1'b1;
                end
                else if (!rv_reg)
                begin
                    emit       = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end

            // response waits for the output register
            bdd_pkg::S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = bdd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bdd_pkg::S_IDLE;
            end
        endcase

        // hand a finished response to the output register or park it
        emit_rsp.popped_value = emit_popped;
        emit_rsp.status       = emit_status;
        emit_rsp.entry_count  = bdd_pkg::COUNT_W'(count_next);
        if (emit)
        begin
            if (!out_valid_reg || rsp_ready)
            begin
                out_next       = emit_rsp;
                out_valid_next = 1'b1;
                state_next     = bdd_pkg::S_IDLE;
            end
            else
            begin
                res_next   = emit_rsp;
                state_next = bdd_pkg::S_RESP;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdd_pkg::S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            iss_reg       <= '0;
            ridx_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            ridx_reg      <= ridx_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        out_reg  <= out_next;
        res_reg  <= res_next;
    end

endmodule

### rtl/bdd_checker.sv
// port-level checks for the bounded deque core, bound to the core module
// depends on bdd_pkg and bounded_deque_with_delete_core_defines.svh
`include "bounded_deque_with_delete_core_defines.svh"

module bdd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input bdd_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bdd_pkg::rsp_t rsp
);

    // a waiting request beat holds
    `BDD_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))

    // a stalled response beat holds
    `BDD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // only a good pop returns a word
    `BDD_ASSERT_NOW(a_fail_no_word, rsp_valid && (rsp.status != bdd_pkg::STATUS_OK), rsp.popped_value == '0)

    // empty status means nothing is held
    `BDD_ASSERT_NOW(a_empty_count, rsp_valid && (rsp.status == bdd_pkg::STATUS_EMPTY), rsp.entry_count == '0)

endmodule

bind bounded_deque_with_delete_core bdd_checker u_bdd_checker (.*);
